// File: hw/rtl/bmp24_stream_decoder_macros.svh
// assertion macros shared by the bmp24 decoder rtl
// each macro expects clk and rst_n in the scope where it is used
`ifndef BMP24_STREAM_DECODER_MACROS_SVH
`define BMP24_STREAM_DECODER_MACROS_SVH

// same-cycle implication, held off during reset
`define BMP24_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmp24 assertion failed");

// next-cycle implication, held off during reset
`define BMP24_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmp24 assertion failed");

`endif

// File: hw/rtl/bmp24_pkg.sv
// types and constants for the bmp24 stream decoder
// no dependencies
`timescale 1ns / 1ps

package bmp24_pkg;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_NEXT  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [2:0] RES_HEADER = 3'd0;
    localparam logic [2:0] RES_PIXEL  = 3'd1;
    localparam logic [2:0] RES_DONE   = 3'd2;
    localparam logic [2:0] RES_BAD    = 3'd3;
    localparam logic [2:0] RES_EARLY  = 3'd4;

    localparam logic [7:0]  SIG_B         = 8'h42;
    localparam logic [7:0]  SIG_M         = 8'h4D;
    localparam logic [15:0] BPP_24        = 16'd24;
    localparam logic [31:0] MAX_DIMENSION = 32'd100000;

    localparam logic [5:0] POS_SIG_B     = 6'd0;
    localparam logic [5:0] POS_SIG_M     = 6'd1;
    localparam logic [5:0] POS_WIDTH     = 6'd18;
    localparam logic [5:0] POS_HEIGHT    = 6'd22;
    localparam logic [5:0] POS_BPP       = 6'd28;
    localparam logic [5:0] POS_HDR_LAST  = 6'd53;

    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [16:0] column;
        logic [16:0] row;
        logic [16:0] image_width;
        logic [16:0] image_height;
        logic        last;
    } result_t;

endpackage

// File: hw/rtl/bmp24_dec.sv
// header parse and pixel assembly state for the bmp24 stream decoder
// depends on bmp24_pkg and bmp24_stream_decoder_macros.svh
`timescale 1ns / 1ps
`include "bmp24_stream_decoder_macros.svh"

module bmp24_dec (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [1:0]        kind,
    input  logic [7:0]        data_byte,
    output bmp24_pkg::result_t res_a,
    output bmp24_pkg::result_t res_b,
    output logic [1:0]        res_n
);

    localparam logic [1:0] PH_WAIT   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  hpos_reg, hpos_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [15:0] bpp_reg, bpp_next;
    logic [16:0] col_reg, col_next;
    logic [16:0] row_reg, row_next;
    logic [1:0]  tri_reg, tri_next;
    logic [1:0]  pad_reg, pad_next;
    logic [7:0]  blue_reg, blue_next;
    logic [7:0]  green_reg, green_next;

    logic        start;
    logic        hdr_active;
    logic        pix_active;
    logic [5:0]  cur_pos;
    logic [31:0] cur_w;
    logic [31:0] cur_h;
    logic [15:0] cur_bpp;
    logic [16:0] col_inc;
    logic [16:0] row_inc;
    logic        row_done;
    logic        hdr_ok;

    always_comb
    begin
        start      = (kind == bmp24_pkg::KIND_START);
        hdr_active = start || (kind == bmp24_pkg::KIND_NEXT && phase_reg == PH_HEADER);
        pix_active = (kind == bmp24_pkg::KIND_NEXT) && (phase_reg == PH_PIXELS);
        cur_pos    = start ? 6'd0 : hpos_reg;
        cur_w      = start ? 32'd0 : width_reg;
        cur_h      = start ? 32'd0 : height_reg;
        cur_bpp    = start ? 16'd0 : bpp_reg;
        col_inc    = col_reg + 17'd1;
        row_inc    = row_reg + 17'd1;
        row_done   = ({15'd0, row_inc} >= height_reg);
        hdr_ok     = (cur_w >= 32'd1) && (cur_w <= bmp24_pkg::MAX_DIMENSION) &&
                     (cur_h >= 32'd1) && (cur_h <= bmp24_pkg::MAX_DIMENSION) &&
                     (cur_bpp == bmp24_pkg::BPP_24);

        phase_next  = start ? PH_HEADER : phase_reg;
        hpos_next   = cur_pos;
        width_next  = cur_w;
        height_next = cur_h;
        bpp_next    = cur_bpp;
        col_next    = start ? 17'd0 : col_reg;
        row_next    = start ? 17'd0 : row_reg;
        tri_next    = start ? 2'd0 : tri_reg;
        pad_next    = start ? 2'd0 : pad_reg;
        blue_next   = start ? 8'd0 : blue_reg;
        green_next  = start ? 8'd0 : green_reg;

        res_a = '0;
        res_b = '0;
        res_n = 2'd0;

        if (hdr_active)
        begin
            if ((cur_pos == bmp24_pkg::POS_SIG_B && data_byte != bmp24_pkg::SIG_B) ||
                (cur_pos == bmp24_pkg::POS_SIG_M && data_byte != bmp24_pkg::SIG_M))
            begin
                res_a.result_kind = bmp24_pkg::RES_BAD;
                res_n             = 2'd1;
                phase_next        = PH_WAIT;
            end
            else
            begin
                case (cur_pos)
                    bmp24_pkg::POS_WIDTH:         width_next[7:0]   = data_byte;
                    bmp24_pkg::POS_WIDTH + 6'd1:  width_next[15:8]  = data_byte;
                    bmp24_pkg::POS_WIDTH + 6'd2:  width_next[23:16] = data_byte;
                    bmp24_pkg::POS_WIDTH + 6'd3:  width_next[31:24] = data_byte;
                    bmp24_pkg::POS_HEIGHT:        height_next[7:0]   = data_byte;
                    bmp24_pkg::POS_HEIGHT + 6'd1: height_next[15:8]  = data_byte;
                    bmp24_pkg::POS_HEIGHT + 6'd2: height_next[23:16] = data_byte;
                    bmp24_pkg::POS_HEIGHT + 6'd3: height_next[31:24] = data_byte;
                    bmp24_pkg::POS_BPP:           bpp_next[7:0]  = data_byte;
                    bmp24_pkg::POS_BPP + 6'd1:    bpp_next[15:8] = data_byte;
                    default:                      hpos_next = cur_pos;
                endcase
                if (cur_pos != bmp24_pkg::POS_HDR_LAST)
                begin
                    hpos_next = cur_pos + 6'd1;
                end
                else if (hdr_ok)
                begin
                    res_a.result_kind  = bmp24_pkg::RES_HEADER;
                    res_a.image_width  = cur_w[16:0];
                    res_a.image_height = cur_h[16:0];
                    res_n              = 2'd1;
                    phase_next         = PH_PIXELS;
                end
                else
                begin
                    res_a.result_kind = bmp24_pkg::RES_BAD;
                    res_n             = 2'd1;
                    phase_next        = PH_WAIT;
                end
            end
        end
        else if (pix_active)
        begin
            if (pad_reg != 2'd0)
            begin
                pad_next = pad_reg - 2'd1;
                if (pad_reg == 2'd1)
                begin
                    col_next = 17'd0;
                    row_next = row_inc;
                    if (row_done)
                    begin
                        res_a.result_kind = bmp24_pkg::RES_DONE;
                        res_n             = 2'd1;
                        phase_next        = PH_WAIT;
                    end
                end
            end
            else if (tri_reg == 2'd0)
            begin
                blue_next = data_byte;
                tri_next  = 2'd1;
            end
            else if (tri_reg == 2'd1)
            begin
                green_next = data_byte;
                tri_next   = 2'd2;
            end
            else
            begin
                tri_next          = 2'd0;
                res_a.result_kind = bmp24_pkg::RES_PIXEL;
                res_a.red         = data_byte;
                res_a.green       = green_reg;
                res_a.blue        = blue_reg;
                res_a.column      = col_reg;
                res_a.row         = row_reg;
                res_n             = 2'd1;
                col_next          = col_inc;
                if ({15'd0, col_inc} >= width_reg)
                begin
                    pad_next = width_reg[1:0];
                    if (width_reg[1:0] == 2'd0)
                    begin
                        col_next = 17'd0;
                        row_next = row_inc;
                        if (row_done)
                        begin
                            res_b.result_kind = bmp24_pkg::RES_DONE;
                            res_n             = 2'd2;
                            phase_next        = PH_WAIT;
                        end
                    end
                end
            end
        end
        else if (kind == bmp24_pkg::KIND_END)
        begin
            if (phase_reg == PH_HEADER)
            begin
                res_a.result_kind = bmp24_pkg::RES_BAD;
                res_n             = 2'd1;
                phase_next        = PH_WAIT;
            end
            else if (phase_reg == PH_PIXELS)
            begin
                res_a.result_kind = bmp24_pkg::RES_EARLY;
                res_n             = 2'd1;
                phase_next        = PH_WAIT;
            end
        end

        if (res_n == 2'd1)
        begin
            res_a.last = 1'b1;
        end
        if (res_n == 2'd2)
        begin
            res_b.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            hpos_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            bpp_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            tri_reg    <= '0;
            pad_reg    <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            bpp_reg    <= bpp_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            tri_reg    <= tri_next;
            pad_reg    <= pad_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
        end
    end

    // two results only for the closing pixel of an unpadded image
    `BMP24_ASSERT_IMPL(a_two_res, res_n == 2'd2,
        res_a.result_kind == bmp24_pkg::RES_PIXEL && res_b.result_kind == bmp24_pkg::RES_DONE)
    `BMP24_ASSERT_NEXT(a_start_hdr,
        fire && kind == bmp24_pkg::KIND_START && data_byte == bmp24_pkg::SIG_B,
        phase_reg == PH_HEADER && hpos_reg == 6'd1)
    `BMP24_ASSERT_IMPL(a_pad_range, phase_reg == PH_PIXELS && pad_reg != 2'd0,
        tri_reg == 2'd0)

endmodule

// File: hw/rtl/bmp24_ofifo.sv
// result queue for the bmp24 stream decoder, up to two words written per cycle
// depends on bmp24_pkg and bmp24_stream_decoder_macros.svh
`timescale 1ns / 1ps
`include "bmp24_stream_decoder_macros.svh"

module bmp24_ofifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         push_n,
    input  bmp24_pkg::result_t wr_a,
    input  bmp24_pkg::result_t wr_b,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output bmp24_pkg::result_t rd
);

    localparam int AW = bmp24_pkg::OFIFO_AW;
    localparam logic [AW:0] DEPTH = AW'(0) + (AW+1)'(bmp24_pkg::OFIFO_DEPTH);

    bmp24_pkg::result_t mem [bmp24_pkg::OFIFO_DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          pop;

    always_comb
    begin
        out_valid   = (count_reg != '0);
        pop         = out_valid && out_ready;
        room        = (count_reg <= DEPTH - (AW+1)'(2));
        rd          = mem[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg + AW'(push_n);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + (AW+1)'(push_n) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= wr_a;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_reg + AW'(1)] <= wr_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `BMP24_ASSERT_IMPL(a_no_overflow, push_n != 2'd0, count_reg <= DEPTH - (AW+1)'(push_n))
    `BMP24_ASSERT_IMPL(a_count_ptrs, 1'b1,
        count_reg == DEPTH || AW'(count_reg) == AW'(wr_ptr_reg - rd_ptr_reg))

endmodule

// File: hw/rtl/bmp24_stream_decoder.sv
// 24-bit bmp byte stream decoder: one input word per cycle while the queue has room
// results pass through a 4-word queue, written from the input stage register
// throughput: 1 input word per cycle while the output side keeps up; a word that
// yields two results is absorbed by the result queue
// reset: rst_n asynchronous, active low, clears the decode state and empties the queue
// depends on bmp24_pkg, bmp24_dec and bmp24_ofifo
`timescale 1ns / 1ps

module bmp24_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  result_kind,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [16:0] column,
    output logic [16:0] row,
    output logic [16:0] image_width,
    output logic [16:0] image_height,
    output logic        last
);

    logic               stage_valid_reg;
    logic [1:0]         kind_reg;
    logic [7:0]         byte_reg;
    logic               room;
    logic               fire;
    logic [1:0]         res_n;
    logic [1:0]         push_n;
    bmp24_pkg::result_t res_a;
    bmp24_pkg::result_t res_b;
    bmp24_pkg::result_t rd;

    assign fire     = stage_valid_reg && room;
    assign in_ready = !stage_valid_reg || fire;
    assign push_n   = fire ? res_n : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_reg <= kind;
            byte_reg <= data_byte;
        end
    end

    bmp24_dec u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .kind      (kind_reg),
        .data_byte (byte_reg),
        .res_a     (res_a),
        .res_b     (res_b),
        .res_n     (res_n)
    );

    bmp24_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .wr_a      (res_a),
        .wr_b      (res_b),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rd        (rd)
    );

    assign result_kind  = rd.result_kind;
    assign red          = rd.red;
    assign green        = rd.green;
    assign blue         = rd.blue;
    assign column       = rd.column;
    assign row          = rd.row;
    assign image_width  = rd.image_width;
    assign image_height = rd.image_height;
    assign last         = rd.last;

endmodule
